FILE: rtl/core/rdit_pkg.sv
// ----------------------------------------------------------------------------
// rdit_pkg
// Types, constants and helper functions for the residual dequantizer and
// inverse 4x4 transform.
// ----------------------------------------------------------------------------
package rdit_pkg;

    // Coefficients are clamped to this many signed bits before scaling.
    localparam int COEF_WIDTH = 16;
    localparam int CoefExtW   = ((COEF_WIDTH > 16) ? COEF_WIDTH : 16) + 1;
    localparam logic signed [CoefExtW-1:0] CoefMax =
        CoefExtW'((64'sd1 <<< (COEF_WIDTH - 1)) - 64'sd1);
    localparam logic signed [CoefExtW-1:0] CoefMin = -CoefMax - CoefExtW'(1);

    // Dequantized coefficient width; 16b coef * 29 << 10 stays below 2^31.
    localparam int DeqW = 32;
    // Transform datapath width, covers growth of both butterfly passes.
    localparam int TrW  = 38;
    localparam int RndOffset = 32;
    localparam int RndShift  = 6;
    localparam int ResMax    = 32767;
    localparam int ResMin    = -32768;
    localparam logic [1:0] LastRow = 2'd3;

    typedef struct packed {
        logic signed [15:0] coef_a;
        logic signed [15:0] coef_b;
        logic signed [15:0] coef_c;
        logic signed [15:0] coef_d;
        logic        [5:0]  quant_param;
        logic               keep_dc;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] res_a;
        logic signed [15:0] res_b;
        logic signed [15:0] res_c;
        logic signed [15:0] res_d;
        logic               last_row;
    } t_out_item;

    // One dequantized row on its way from the front to the back.
    typedef struct packed {
        logic [1:0]            row;
        logic [3:0][DeqW-1:0]  coef;
    } t_deq_row;

    typedef logic [3:0][TrW-1:0] t_tr_vec;

    typedef enum logic [1:0] {
        BK_COLLECT,
        BK_COLUMN,
        BK_DRAIN
    } t_back_state;

    // qp / 6 for a 6-bit qp: (qp * 43) >> 8 is exact up to 63.
    function automatic logic [3:0] qp_div6(input logic [5:0] qp);
        logic [11:0] t;
        t = 12'(qp) * 12'd43;
        return t[11:8];
    endfunction

    // Flat-matrix dequant factor by qp % 6 and position class.
    function automatic logic [4:0] dq_factor(input logic [2:0] rem,
                                             input logic [1:0] cls);
        logic [4:0] f0, f1, f2;
        unique case (rem)
            3'd0: begin f0 = 5'd10; f1 = 5'd13; f2 = 5'd16; end
            3'd1: begin f0 = 5'd11; f1 = 5'd14; f2 = 5'd18; end
            3'd2: begin f0 = 5'd13; f1 = 5'd16; f2 = 5'd20; end
            3'd3: begin f0 = 5'd14; f1 = 5'd18; f2 = 5'd23; end
            3'd4: begin f0 = 5'd16; f1 = 5'd20; f2 = 5'd25; end
            3'd5: begin f0 = 5'd18; f1 = 5'd23; f2 = 5'd29; end
            default: begin f0 = 5'd10; f1 = 5'd13; f2 = 5'd16; end
        endcase
        unique case (cls)
            2'd0:    return f0;
            2'd1:    return f1;
            2'd2:    return f2;
            default: return f0;
        endcase
    endfunction

    function automatic logic signed [15:0] sat_coef(input logic signed [15:0] c);
        logic signed [CoefExtW-1:0] x;
        x = CoefExtW'(c);
        if (x > CoefMax) begin
            return CoefMax[15:0];
        end else if (x < CoefMin) begin
            return CoefMin[15:0];
        end
        return c;
    endfunction

    // H.264 inverse 4x4 integer butterfly.
    function automatic t_tr_vec butterfly(input t_tr_vec a);
        logic signed [TrW-1:0] a0, a1, a2, a3, e0, e1, e2, e3;
        t_tr_vec o;
        a0 = $signed(a[0]);
        a1 = $signed(a[1]);
        a2 = $signed(a[2]);
        a3 = $signed(a[3]);
        e0 = a0 + a2;
        e1 = a0 - a2;
        e2 = (a1 >>> 1) - a3;
        e3 = a1 + (a3 >>> 1);
        o[0] = e0 + e3;
        o[1] = e1 + e2;
        o[2] = e1 - e2;
        o[3] = e0 - e3;
        return o;
    endfunction

    // (h + 32) >> 6, saturated to 16 bits.
    function automatic logic signed [15:0] rnd_sat(input logic [TrW-1:0] h);
        logic signed [TrW-1:0] s;
        s = ($signed(h) + TrW'(RndOffset)) >>> RndShift;
        if (s > TrW'(ResMax)) begin
            return 16'(ResMax);
        end else if (s < TrW'(ResMin)) begin
            return 16'(ResMin);
        end
        return s[15:0];
    endfunction

endpackage

FILE: rtl/core/residual_dequant_inverse_transform_core.sv
// ----------------------------------------------------------------------------
// residual_dequant_inverse_transform_core
// H.264 4x4 residual dequantizer and inverse integer transform.
// ----------------------------------------------------------------------------
// A 4x4 block enters as four row transfers; the quantizer and DC flag are
// taken with the first row. The front dequantizes a row per cycle into a
// two-row queue while the queue has room. The back pulls four rows through
// the row butterfly, runs the column butterflies in its COLUMN state, then
// delivers four residual rows, the last flagged with last_row, one per cycle
// when not stalled. The back handles one block at a time and pops no row of
// the next block before the last residual row is loaded; the front absorbs
// up to three rows while the back drains. With the back idle, the fourth
// row goes through the front register, the queue, r_f and r_h to o_valid.
module residual_dequant_inverse_transform_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  rdit_pkg::t_in_item   i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output rdit_pkg::t_out_item  o_data
);

    logic               push, full, q_valid, q_pop;
    rdit_pkg::t_deq_row front_row, q_row;

    rdit_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_push  (push),
        .o_row   (front_row),
        .i_full  (full)
    );

    rdit_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_row),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_row),
        .i_pop   (q_pop)
    );

    rdit_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_row),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .o_data    (o_data),
        .i_stall   (i_stall)
    );

endmodule

FILE: rtl/core/rdit_front.sv
// ----------------------------------------------------------------------------
// rdit_front
// Accepts coefficient rows, latches the block quantizer and dequantizes
// each row into a register that feeds the row queue.
// ----------------------------------------------------------------------------
module rdit_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  rdit_pkg::t_in_item  i_data,
    output logic                o_push,
    output rdit_pkg::t_deq_row  o_row,
    input  logic                i_full
);

    logic [1:0]  r_row_cnt;
    logic [5:0]  r_qp;
    logic        r_keep_dc;
    logic        r_valid;
    logic        n_valid;
    rdit_pkg::t_deq_row r_out;

    logic        accept;
    logic [5:0]  qp;
    logic        kdc;
    logic [3:0]  shf;
    logic [5:0]  rem6;
    logic signed [15:0] coefs [4];
    logic signed [15:0] csat  [4];
    logic [4:0]  fac [4];
    logic signed [21:0] prod [4];
    logic [3:0][rdit_pkg::DeqW-1:0] deq;

    assign o_stall = r_valid && i_full;
    assign o_push  = r_valid && !i_full;
    assign accept  = i_valid && !o_stall;
    assign o_row   = r_out;

    // Quantizer and flag come straight from the item on the first row.
    assign qp   = (r_row_cnt == 2'd0) ? i_data.quant_param : r_qp;
    assign kdc  = (r_row_cnt == 2'd0) ? i_data.keep_dc : r_keep_dc;
    assign shf  = rdit_pkg::qp_div6(qp);
    assign rem6 = qp - 6'(6'(shf) * 6'd6);

    assign coefs[0] = i_data.coef_a;
    assign coefs[1] = i_data.coef_b;
    assign coefs[2] = i_data.coef_c;
    assign coefs[3] = i_data.coef_d;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            csat[j] = rdit_pkg::sat_coef(coefs[j]);
            fac[j]  = rdit_pkg::dq_factor(rem6[2:0],
                          {1'b0, r_row_cnt[0]} + {1'b0, 1'(j)});
            prod[j] = csat[j] * $signed({1'b0, fac[j]});
            deq[j]  = rdit_pkg::DeqW'(prod[j]) <<< shf;
        end
        if (r_row_cnt == 2'd0 && kdc) begin
            deq[0] = rdit_pkg::DeqW'(csat[0]);
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= '0;
            r_qp      <= '0;
            r_keep_dc <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (accept) begin
                r_row_cnt <= r_row_cnt + 2'd1;
                if (r_row_cnt == 2'd0) begin
                    r_qp      <= i_data.quant_param;
                    r_keep_dc <= i_data.keep_dc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out.row  <= r_row_cnt;
            r_out.coef <= deq;
        end
    end

endmodule

FILE: rtl/core/rdit_fifo.sv
// ----------------------------------------------------------------------------
// rdit_fifo
// Two-entry queue of dequantized rows between the front and the back.
// ----------------------------------------------------------------------------
module rdit_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rdit_pkg::t_deq_row  i_data,
    output logic                o_full,
    output logic                o_valid,
    output rdit_pkg::t_deq_row  o_data,
    input  logic                i_pop
);

    rdit_pkg::t_deq_row r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: rtl/core/rdit_back.sv
// ----------------------------------------------------------------------------
// rdit_back
// Gathers four dequantized rows through the row butterfly, runs the column
// butterflies, then delivers four rounded residual rows.
// ----------------------------------------------------------------------------
module rdit_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  rdit_pkg::t_deq_row  i_q_data,
    output logic                o_q_pop,
    output logic                o_valid,
    output rdit_pkg::t_out_item o_data,
    input  logic                i_stall
);

    rdit_pkg::t_back_state r_state, n_state;

    logic [rdit_pkg::TrW-1:0] r_f [4][4];
    logic [rdit_pkg::TrW-1:0] r_h [4][4];
    logic [1:0]          r_orow;
    logic                r_out_valid;
    rdit_pkg::t_out_item r_out;

    logic pop, col_ld, out_ld;
    rdit_pkg::t_tr_vec row_in, row_res;
    rdit_pkg::t_tr_vec col_in  [4];
    rdit_pkg::t_tr_vec col_res [4];

    assign o_q_pop = pop;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rdit_pkg::BK_COLLECT: begin
                if (i_q_valid && i_q_data.row == rdit_pkg::LastRow) begin
                    n_state = rdit_pkg::BK_COLUMN;
                end
            end
            rdit_pkg::BK_COLUMN: begin
                n_state = rdit_pkg::BK_DRAIN;
            end
            rdit_pkg::BK_DRAIN: begin
                if (out_ld && r_orow == rdit_pkg::LastRow) begin
                    n_state = rdit_pkg::BK_COLLECT;
                end
            end
            default: n_state = rdit_pkg::BK_COLLECT;
        endcase
    end

    always_comb begin
        pop    = 1'b0;
        col_ld = 1'b0;
        out_ld = 1'b0;
        unique case (r_state)
            rdit_pkg::BK_COLLECT: pop    = i_q_valid;
            rdit_pkg::BK_COLUMN:  col_ld = 1'b1;
            rdit_pkg::BK_DRAIN:   out_ld = !r_out_valid || !i_stall;
            default: ;
        endcase
    end

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            row_in[j] = rdit_pkg::TrW'($signed(i_q_data.coef[j]));
        end
        row_res = rdit_pkg::butterfly(row_in);
        for (int j = 0; j < 4; j++) begin
            for (int i = 0; i < 4; i++) begin
                col_in[j][i] = r_f[i][j];
            end
            col_res[j] = rdit_pkg::butterfly(col_in[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rdit_pkg::BK_COLLECT;
            r_orow      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (col_ld) begin
                r_orow <= '0;
            end else if (out_ld) begin
                r_orow <= r_orow + 2'd1;
            end
            if (out_ld) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            for (int j = 0; j < 4; j++) begin
                r_f[i_q_data.row][j] <= row_res[j];
            end
        end
        if (col_ld) begin
            for (int j = 0; j < 4; j++) begin
                for (int i = 0; i < 4; i++) begin
                    r_h[i][j] <= col_res[j][i];
                end
            end
        end
        if (out_ld) begin
            r_out.res_a    <= rdit_pkg::rnd_sat(r_h[r_orow][0]);
            r_out.res_b    <= rdit_pkg::rnd_sat(r_h[r_orow][1]);
            r_out.res_c    <= rdit_pkg::rnd_sat(r_h[r_orow][2]);
            r_out.res_d    <= rdit_pkg::rnd_sat(r_h[r_orow][3]);
            r_out.last_row <= (r_orow == rdit_pkg::LastRow);
        end
    end

endmodule

FILE: rtl/core/rdit_checker.sv
// ----------------------------------------------------------------------------
// rdit_checker
// Port-level checks on the residual transform core, bound to the top level.
// ----------------------------------------------------------------------------
module rdit_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input rdit_pkg::t_out_item o_data
);

    logic       in_xfer, out_xfer;
    logic [1:0] r_icnt, r_ocnt;
    logic [2:0] r_pend;

    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = o_valid && !i_stall;

    // Blocks fully received minus blocks fully delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_icnt <= '0;
            r_ocnt <= '0;
            r_pend <= '0;
        end else begin
            if (in_xfer) begin
                r_icnt <= r_icnt + 2'd1;
            end
            if (out_xfer) begin
                r_ocnt <= r_ocnt + 2'd1;
            end
            r_pend <= r_pend + 3'(in_xfer && r_icnt == rdit_pkg::LastRow)
                             - 3'(out_xfer && o_data.last_row);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled output changed");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer |-> (o_data.last_row == (r_ocnt == rdit_pkg::LastRow)))
        else $error("last_row out of place");

    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_pend != 3'd0))
        else $error("output without a complete block");

endmodule

bind residual_dequant_inverse_transform_core rdit_checker u_rdit_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

FILE: sim/residual_dequant_inverse_transform_core_tb.sv
// ----------------------------------------------------------------------------
// residual_dequant_inverse_transform_core_tb
// Feeds 4x4 coefficient blocks, one row per transfer, to the dequantizer and
// inverse transform core. A local model of the dequant scaling, both
// butterfly passes, rounding and saturation predicts each residual row, and
// every residual transfer is checked against the oldest prediction. A short
// table of hand-picked blocks runs first. Random blocks follow under three
// back-pressure mixes.
// ----------------------------------------------------------------------------
module residual_dequant_inverse_transform_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef longint t_quad [4];

    typedef struct {
        rdit_pkg::t_in_item row;
        bit                 flat_known;  // every residual of the block is known
        logic signed [15:0] flat;
    } t_dir_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    rdit_pkg::t_in_item  i_data;
    logic                o_valid;
    logic                i_stall;
    rdit_pkg::t_out_item o_data;

    // dequantized block, row counter and per-block settings of the model
    int         deq_coef [16];
    logic [1:0] blk_row;
    logic [5:0] blk_qp;
    logic       blk_keep_dc;

    rdit_pkg::t_out_item expected_residuals [$];
    int        err_count = 0;
    int        src_idle_pct;
    int        snk_idle_pct;

    t_dir_row  directed_rows [24];

    residual_dequant_inverse_transform_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic longint clamp_signed(input longint v, input int w);
        longint hi, lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // flat-matrix scale for qp % 6; class 0 both even, 1 mixed, 2 both odd
    function automatic longint dq_scale(input int rem, input int cls);
        logic [14:0] f;
        case (rem)
            0: f = {5'd16, 5'd13, 5'd10};
            1: f = {5'd18, 5'd14, 5'd11};
            2: f = {5'd20, 5'd16, 5'd13};
            3: f = {5'd23, 5'd18, 5'd14};
            4: f = {5'd25, 5'd20, 5'd16};
            default: f = {5'd29, 5'd23, 5'd18};
        endcase
        return longint'(f[cls*5 +: 5]);
    endfunction

    function automatic void inv_butterfly(input t_quad a, output t_quad o);
        longint e0, e1, e2, e3;
        e0 = a[0] + a[2];
        e1 = a[0] - a[2];
        e2 = (a[1] >>> 1) - a[3];
        e3 = a[1] + (a[3] >>> 1);
        o[0] = e0 + e3;
        o[1] = e1 + e2;
        o[2] = e1 - e2;
        o[3] = e0 - e3;
    endfunction

    // Dequantize one accepted row; on the fourth row queue the residual rows.
    function automatic void predict_block_row(input rdit_pkg::t_in_item it,
                                              input bit flat_known,
                                              input logic signed [15:0] flat);
        logic signed [15:0]  cf [4];
        longint              c, d;
        t_quad               f [4];
        t_quad               a, h;
        logic [15:0]         res [4][4];
        rdit_pkg::t_out_item o;
        int                  r;
        r = int'(blk_row);
        if (r == 0) begin
            blk_qp = it.quant_param;
            blk_keep_dc = it.keep_dc;
        end
        cf = '{it.coef_a, it.coef_b, it.coef_c, it.coef_d};
        for (int j = 0; j < 4; j++) begin
            c = clamp_signed(longint'(cf[j]), rdit_pkg::COEF_WIDTH);
            if (r == 0 && j == 0 && blk_keep_dc) begin
                d = c;
            end else begin
                d = c * dq_scale(int'(blk_qp) % 6, (r & 1) + (j & 1))
                      * (longint'(1) << (int'(blk_qp) / 6));
            end
            deq_coef[r*4 + j] = int'(clamp_signed(d, 32));
        end
        blk_row = blk_row + 2'd1;
        if (r != 3) return;

        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) a[j] = longint'(deq_coef[i*4 + j]);
            inv_butterfly(a, f[i]);
        end
        for (int j = 0; j < 4; j++) begin
            for (int i = 0; i < 4; i++) a[i] = f[i][j];
            inv_butterfly(a, h);
            for (int i = 0; i < 4; i++)
                res[i][j] = 16'(clamp_signed((h[i] + 32) >>> 6, 16));
        end
        for (int i = 0; i < 4; i++) begin
            if (flat_known) begin
                o.res_a = flat;
                o.res_b = flat;
                o.res_c = flat;
                o.res_d = flat;
            end else begin
                o.res_a = res[i][0];
                o.res_b = res[i][1];
                o.res_c = res[i][2];
                o.res_d = res[i][3];
            end
            o.last_row = (i == 3);
            expected_residuals.push_back(o);
        end
    endfunction

    function automatic t_dir_row mk_row(input int ca, input int cb, input int cc,
                                        input int cd, input int qp, input bit kdc,
                                        input bit known, input int flat);
        t_dir_row t;
        t.row.coef_a = 16'(ca);
        t.row.coef_b = 16'(cb);
        t.row.coef_c = 16'(cc);
        t.row.coef_d = 16'(cd);
        t.row.quant_param = 6'(qp);
        t.row.keep_dc = kdc;
        t.flat_known = known;
        t.flat = 16'(flat);
        return t;
    endfunction

    // mostly small and zero values, like real residual data, plus extremes
    function automatic logic signed [15:0] pick_coef();
        case ($urandom_range(9))
            0, 1, 2: return '0;
            3, 4, 5: return 16'($signed($urandom_range(64)) - 32);
            6, 7:    return 16'($signed($urandom_range(4095)) - 2048);
            8:       return 16'($urandom);
            default: begin
                case ($urandom_range(3))
                    0: return 16'sh7fff;
                    1: return 16'sh8000;
                    2: return 16'sh0001;
                    default: return 16'shffff;
                endcase
            end
        endcase
    endfunction

    task automatic send_row(input rdit_pkg::t_in_item row_item, input bit flat_known,
                            input logic signed [15:0] flat);
        logic [95:0] junk;
        while ($urandom_range(99) < src_idle_pct) begin
            junk = {$urandom, $urandom, $urandom};
            i_valid <= 1'b0;
            i_data  <= junk[$bits(rdit_pkg::t_in_item)-1:0];
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= row_item;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_block_row(row_item, flat_known, flat);
    endtask

    task automatic send_random_blocks(input int n_blocks);
        rdit_pkg::t_in_item it;
        for (int b = 0; b < n_blocks; b++) begin
            for (int r = 0; r < 4; r++) begin
                it.coef_a = pick_coef();
                it.coef_b = pick_coef();
                it.coef_c = pick_coef();
                it.coef_d = pick_coef();
                // qp above 51 only now and then
                it.quant_param = ($urandom_range(4) == 0) ? 6'($urandom_range(63, 52))
                                                          : 6'($urandom_range(51));
                it.keep_dc = $urandom_range(1);
                send_row(it, 1'b0, '0);
            end
        end
    endtask

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d",
                     $time, name, $signed(exp_v), $signed(act_v));
            err_count++;
        end
    endfunction

    // residual transfer checker
    always @(posedge i_clk) begin
        rdit_pkg::t_out_item exp_o;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (expected_residuals.size() == 0) begin
                $display("%0t: unexpected residual transfer, got %h", $time, o_data);
                err_count++;
            end else begin
                exp_o = expected_residuals.pop_front();
                check_field("res_a", exp_o.res_a, o_data.res_a);
                check_field("res_b", exp_o.res_b, o_data.res_b);
                check_field("res_c", exp_o.res_c, o_data.res_c);
                check_field("res_d", exp_o.res_d, o_data.res_d);
                check_field("last_row", 16'(exp_o.last_row), 16'(o_data.last_row));
            end
        end
    end

    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            i_stall <= ($urandom_range(99) < snk_idle_pct);
        end
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        src_idle_pct = 12;
        snk_idle_pct = 69;
        blk_row = '0;
        blk_qp = '0;
        blk_keep_dc = 1'b0;
        foreach (deq_coef[k]) deq_coef[k] = 0;

        directed_rows = '{
            // all-zero block
            mk_row(0, 0, 0, 0, 0, 0, 0, 0),
            mk_row(0, 0, 0, 0, 0, 0, 0, 0),
            mk_row(0, 0, 0, 0, 0, 0, 0, 0),
            mk_row(0, 0, 0, 0, 0, 0, 1, 0),
            // unscaled DC of 64 spreads to 1 everywhere; later qp/flag ignored
            mk_row(64, 0, 0, 0, 0, 1, 0, 0),
            mk_row(0, 0, 0, 0, 63, 0, 0, 0),
            mk_row(0, 0, 0, 0, 63, 0, 0, 0),
            mk_row(0, 0, 0, 0, 63, 0, 1, 1),
            // most negative unscaled DC, rounds toward minus infinity
            mk_row(-32768, 0, 0, 0, 0, 1, 0, 0),
            mk_row(0, 0, 0, 0, 0, 0, 0, 0),
            mk_row(0, 0, 0, 0, 0, 0, 0, 0),
            mk_row(0, 0, 0, 0, 0, 0, 1, -512),
            // full-scale positive at the largest 6-bit qp
            mk_row(32767, 32767, 32767, 32767, 63, 0, 0, 0),
            mk_row(32767, 32767, 32767, 32767, 0, 1, 0, 0),
            mk_row(32767, 32767, 32767, 32767, 0, 1, 0, 0),
            mk_row(32767, 32767, 32767, 32767, 0, 1, 0, 0),
            // full-scale negative, top legal qp, DC kept
            mk_row(-32768, -32768, -32768, -32768, 51, 1, 0, 0),
            mk_row(-32768, -32768, -32768, -32768, 51, 1, 0, 0),
            mk_row(-32768, -32768, -32768, -32768, 51, 1, 0, 0),
            mk_row(-32768, -32768, -32768, -32768, 51, 1, 0, 0),
            // checkerboard of extremes, qp just past the legal range
            mk_row(32767, -32768, 32767, -32768, 52, 0, 0, 0),
            mk_row(-32768, 32767, -32768, 32767, 5, 1, 0, 0),
            mk_row(32767, -32768, 32767, -32768, 5, 1, 0, 0),
            mk_row(-32768, 32767, -32768, 32767, 5, 1, 0, 0)
        };

        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_row(directed_rows[k].row, directed_rows[k].flat_known, directed_rows[k].flat);

        send_random_blocks(40);
        src_idle_pct = 69;
        snk_idle_pct = 12;
        send_random_blocks(40);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        send_random_blocks(40);
        i_valid <= 1'b0;

        while (expected_residuals.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
